### rtl/deq_pkg.sv
// Shared widths, command codes and status codes of the double-ended queue.
package deq_pkg;

    // Field widths of one request and of one result.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    // Stream widths: the command travels in tuser, the rest is packed in tdata.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 40;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_NTH   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT      = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

### rtl/deq_slot.sv
// Ring address unit: maps an offset from the front entry to a physical slot.
module deq_slot #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic [AW-1:0] head,
    input  logic [AW-1:0] offset,
    output logic [AW-1:0] slot
);

    logic [AW:0] sum;

    // One add and one compare-subtract folds the sum back into the ring.
    always_comb begin
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        slot = sum[AW-1:0];
    end

endmodule

### rtl/deq_ram.sv
// Entry store of the queue: one write port and one registered read port.
module deq_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [deq_pkg::VALUE_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [deq_pkg::VALUE_W-1:0]    rd_data
);

    import deq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/deque_with_index_and_count.sv
// Top level of the bounded double-ended queue with read-at-position and match count.
//
// Requests enter on the s_ stream: s_tuser carries the command, s_tdata the value
// and the position. Each request gives exactly one result on the m_ stream:
// the value read, the length for a read past the end, or the match count, plus
// a status (ok, push into a full store dropped, pop of an empty store ignored).
// One request is handled at a time; s_tready is low while it is being worked on.
// Push and pop go through the execute and done states; read nth waits for its read between them.
// Count walks the stored entries through the single read port of the entry store
// and one equality comparator, one entry per cycle, before the done state.
// The next request is taken in the idle state entered when the result is loaded,
// so no new request is taken until the result of the last one is loaded.
// The result sits in an output register; the block takes the next request while
// it waits. If the receiver stalls, the next result is held back until the
// output register is free.
// Reset (aresetn low at a clock edge) empties the queue and clears the output
// valid; the entry store itself is not cleared and needs no clearing pass.
module deque_with_index_and_count #(
    parameter int DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value [31:0], position [41:32], zero fill [47:42]
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd [2:0]
    input  logic [deq_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value [31:0], status [33:32], zero fill [39:34]
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);

    import deq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_COUNT,
        S_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic [CMD_W-1:0]       cmd_reg,    cmd_next;
    logic [VALUE_W-1:0]     value_reg,  value_next;
    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic [AW-1:0]          head_reg,   head_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic [CW-1:0]          idx_reg,    idx_next;
    logic [CW-1:0]          match_reg,  match_next;
    logic                   pend_reg,   pend_next;
    logic [VALUE_W-1:0]     res_reg,    res_next;
    logic [STATUS_W-1:0]    stat_reg,   stat_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg,  m_data_next;

    logic                   full;
    logic                   empty;
    logic                   pos_in_range;
    logic                   idx_in_range;
    logic                   hit;
    logic [AW-1:0]          head_dec;
    logic [AW-1:0]          slot_off;
    logic [AW-1:0]          slot;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [VALUE_W-1:0]     rd_data;

    // Queue occupancy and range checks.
    assign full         = (count_reg == CW'(DEPTH));
    assign empty        = (count_reg == '0);
    assign pos_in_range = (CMPW'(pos_reg) < CMPW'(count_reg));
    assign idx_in_range = (idx_reg < count_reg);
    assign hit          = pend_reg && (rd_data == value_reg);
    assign head_dec     = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;

    // Offset fed to the shared ring address unit.
    always_comb begin
        slot_off = '0;
        if (state_reg == S_COUNT) begin
            slot_off = idx_reg[AW-1:0];
        end else begin
            case (cmd_reg)
                CMD_PUSH_BACK: slot_off = count_reg[AW-1:0];
                CMD_POP_FRONT: slot_off = AW'(1);
                CMD_READ_NTH:  slot_off = AW'(pos_reg);
                default:       slot_off = '0;
            endcase
        end
    end

    deq_slot #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slot (
        .head   (head_reg),
        .offset (slot_off),
        .slot   (slot)
    );

    // Entry store port controls.
    always_comb begin
        wr_en   = (state_reg == S_EXEC) && !full &&
                  ((cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK));
        wr_addr = (cmd_reg == CMD_PUSH_FRONT) ? head_dec : slot;
        rd_en   = ((state_reg == S_EXEC) && (cmd_reg == CMD_READ_NTH) && pos_in_range) ||
                  ((state_reg == S_COUNT) && idx_in_range);
    end

    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // Sequencer: next state and register values.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        match_next   = match_reg;
        pend_next    = 1'b0;
        res_next     = res_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // The output register empties when the receiver takes the result.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    value_next = s_tdata[VALUE_W-1:0];
                    pos_next   = s_tdata[VALUE_W +: POS_W];
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_next   = '0;
                stat_next  = STAT_OK;
                state_next = S_DONE;
                unique case (cmd_reg) inside
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (full) begin
                            stat_next = STAT_FULL;
                        end else begin
                            count_next = count_reg + 1'b1;
                            if (cmd_reg == CMD_PUSH_FRONT) begin
                                head_next = head_dec;
                            end
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (empty) begin
                            stat_next = STAT_EMPTY;
                        end else begin
                            count_next = count_reg - 1'b1;
                            if (cmd_reg == CMD_POP_FRONT) begin
                                head_next = slot;
                            end
                        end
                    end
                    CMD_READ_NTH: begin
                        if (pos_in_range) begin
                            state_next = S_READ_WAIT;
                        end else begin
                            res_next = VALUE_W'(count_reg);
                        end
                    end
                    CMD_COUNT: begin
                        idx_next   = '0;
                        match_next = '0;
                        state_next = S_COUNT;
                    end
                    default: begin
                        res_next = '0;
                    end
                endcase
            end

            S_READ_WAIT: begin
                res_next   = rd_data;
                state_next = S_DONE;
            end

            // One entry read and one compare per cycle; the last compare
            // lands in the cycle after the last read.
            S_COUNT: begin
                match_next = match_reg + CW'(hit);
                if (idx_in_range) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    res_next   = VALUE_W'(match_next);
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({stat_reg, res_reg});
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        match_reg  <= match_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
